### rtl/core/blrt_pkg.sv
// Shared types and constants for the budgeted LRU residency table.
// Holds item structs, opcodes, controller states and the command/status bundles.
// Depends on nothing.
package blrt_pkg;

	localparam int ENTRIES = 32;
	localparam int IDX_W = 5;
	localparam int CNT_W = 32;
	localparam int SIZE_W = 32;
	localparam int BYTES_W = 40;
	localparam int ORD_W = 64;
	localparam int DONE_W = 6;
	localparam logic [DONE_W-1:0] MAX_EVICT = DONE_W'(32);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

	localparam logic [3:0] OP_TOUCH = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_RETAIN = 4'd2;
	localparam logic [3:0] OP_RELEASE = 4'd3;
	localparam logic [3:0] OP_UNLOAD = 4'd4;
	localparam logic [3:0] OP_PIN = 4'd5;
	localparam logic [3:0] OP_UNPIN = 4'd6;
	localparam logic [3:0] OP_ENFORCE = 4'd7;
	localparam logic [3:0] OP_PROTECT = 4'd8;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_RES = 2'd1;
	localparam logic [1:0] ST_BUDGET = 2'd2;
	localparam logic [1:0] ST_LIMIT = 2'd3;

	typedef struct packed {
		logic [3:0] opcode;
		logic [IDX_W-1:0] entry_index;
		logic [SIZE_W-1:0] load_size;
	} in_item_t;

	typedef struct packed {
		logic evicted;
		logic [IDX_W-1:0] result_index;
		logic [1:0] status;
		logic [BYTES_W-1:0] used_bytes;
		logic last;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_CHECK,
		S_SCAN,
		S_EVICT,
		S_FINAL
	} state_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic install;
		logic fail;
		logic clr_prot;
		logic scan_start;
		logic scan_step;
		logic evict;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic needs_check;
		logic is_load;
		logic chk_pass;
		logic chk_fail;
		logic scan_last;
		logic found;
	} stat_t;

endpackage

### rtl/core/budgeted_lru_residency_table_unit.sv
// Budgeted LRU residency table, top level: controller plus datapath.
// Flow: an operation without budget check passes the execute and final states before its
// final item; a load of an absent entry or an enforce adds a budget check state. Each
// eviction adds a check, an LRU scan over all 32 entries and an eviction state. A new
// item is accepted only once the previous one has finished and the controller is idle.
// Reset clears residency, counts, protect marks, bytes in use, ordinal and budget at once.
// Results are strobed for a single cycle; the receiver cannot stall them.
module budgeted_lru_residency_table_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  blrt_pkg::in_item_t          item,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [blrt_pkg::SIZE_W-1:0] cfg_data,
	output blrt_pkg::out_item_t         result,
	output logic                        result_valid
);

	blrt_pkg::cmd_t  cmd;
	blrt_pkg::stat_t stat;
	logic            start_ok;

	// An item is taken only while the controller is idle.
	assign start_ok = start && !busy;

	// Budget can always be written; software must write it only when idle (not enforced).
	assign cfg_ready = 1'b1;

	blrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_ok),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	blrt_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

### rtl/core/blrt_ctrl.sv
// Controller state machine for the budgeted LRU residency table.
// Depends on blrt_pkg; drives the datapath by command bundle only.
module blrt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  blrt_pkg::stat_t stat,
	output blrt_pkg::cmd_t  cmd,
	output logic            busy
);

	blrt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blrt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			blrt_pkg::S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d = blrt_pkg::S_EXEC;
				end
			end
			blrt_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				// A load of a resident entry consumes the protect marks too.
				if (!stat.needs_check) begin
					cmd.clr_prot = stat.is_load;
				end
				state_d = stat.needs_check ? blrt_pkg::S_CHECK : blrt_pkg::S_FINAL;
			end
			blrt_pkg::S_CHECK: begin
				if (stat.chk_pass) begin
					cmd.install = stat.is_load;
					cmd.clr_prot = 1'b1;
					state_d = blrt_pkg::S_FINAL;
				end else if (stat.chk_fail) begin
					cmd.fail = 1'b1;
					cmd.clr_prot = 1'b1;
					state_d = blrt_pkg::S_FINAL;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = blrt_pkg::S_SCAN;
				end
			end
			blrt_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = blrt_pkg::S_EVICT;
				end
			end
			blrt_pkg::S_EVICT: begin
				if (stat.found) begin
					cmd.evict = 1'b1;
					state_d = blrt_pkg::S_CHECK;
				end else begin
					cmd.fail = 1'b1;
					cmd.clr_prot = 1'b1;
					state_d = blrt_pkg::S_FINAL;
				end
			end
			blrt_pkg::S_FINAL: begin
				cmd.fin = 1'b1;
				state_d = blrt_pkg::S_IDLE;
			end
			default: begin
				state_d = blrt_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != blrt_pkg::S_IDLE);

endmodule

### rtl/core/blrt_datapath.sv
// Datapath for the budgeted LRU residency table: entry tables, counters,
// budget check, LRU scan and result register. Depends on blrt_pkg.
module blrt_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  blrt_pkg::in_item_t            item,
	input  logic                          cfg_we,
	input  logic [blrt_pkg::SIZE_W-1:0]   cfg_data,
	input  blrt_pkg::cmd_t                cmd,
	output blrt_pkg::stat_t               stat,
	output blrt_pkg::out_item_t           result,
	output logic                          result_valid
);

	localparam int E = blrt_pkg::ENTRIES;

	logic [3:0]                       op_q;
	logic [blrt_pkg::IDX_W-1:0]       idx_q;
	logic [blrt_pkg::SIZE_W-1:0]      size_q;
	logic [1:0]                       st_q;
	logic [blrt_pkg::DONE_W-1:0]      done_q;
	logic [blrt_pkg::IDX_W-1:0]       scan_q;
	logic [blrt_pkg::IDX_W-1:0]       best_q;
	logic [blrt_pkg::ORD_W-1:0]       best_lu_q;
	logic                             found_q;
	logic [blrt_pkg::SIZE_W-1:0]      budget_q;
	logic [blrt_pkg::BYTES_W-1:0]     bytes_q;
	logic [blrt_pkg::ORD_W-1:0]       acc_q;
	logic [E-1:0]                     res_q;
	logic [E-1:0]                     prot_q;
	logic [blrt_pkg::CNT_W-1:0]       ret_q [E];
	logic [blrt_pkg::CNT_W-1:0]       dep_q [E];
	logic [blrt_pkg::SIZE_W-1:0]      eb_q [E];
	logic [blrt_pkg::ORD_W-1:0]       lu_q [E];
	blrt_pkg::out_item_t              out_q;
	logic                             strobe_q;

	logic [blrt_pkg::IDX_W-1:0]       addr;
	logic                             a_res;
	logic [blrt_pkg::CNT_W-1:0]       a_ret;
	logic [blrt_pkg::CNT_W-1:0]       a_dep;
	logic [blrt_pkg::SIZE_W-1:0]      a_eb;
	logic [blrt_pkg::ORD_W-1:0]       a_lu;
	logic                             a_cand;
	logic [blrt_pkg::ORD_W-1:0]       acc_inc;
	logic [blrt_pkg::ORD_W-1:0]       next_ord;
	logic [blrt_pkg::SIZE_W-1:0]      add;
	logic [blrt_pkg::BYTES_W-1:0]     limit;
	logic                             need;
	logic [blrt_pkg::BYTES_W-1:0]     bytes_sub;
	logic [blrt_pkg::BYTES_W:0]       bytes_sum;
	logic [blrt_pkg::BYTES_W-1:0]     bytes_add;

	// One table read port, steered by the current phase.
	assign addr = cmd.scan_step ? scan_q : (cmd.evict ? best_q : idx_q);
	assign a_res = res_q[addr];
	assign a_ret = ret_q[addr];
	assign a_dep = dep_q[addr];
	assign a_eb = eb_q[addr];
	assign a_lu = lu_q[addr];
	assign a_cand = a_res && (a_ret == '0) && (a_dep == '0) && !prot_q[addr];

	assign acc_inc = acc_q + blrt_pkg::ORD_W'(1);
	assign next_ord = (acc_inc == '0) ? blrt_pkg::ORD_W'(1) : acc_inc;

	assign add = (op_q == blrt_pkg::OP_LOAD) ? size_q : '0;
	assign limit = blrt_pkg::BYTES_W'(budget_q - add);
	assign need = bytes_q > limit;
	assign bytes_sub = (blrt_pkg::BYTES_W'(a_eb) <= bytes_q) ?
		bytes_q - blrt_pkg::BYTES_W'(a_eb) : '0;
	assign bytes_sum = {1'b0, bytes_q} + (blrt_pkg::BYTES_W + 1)'(size_q);
	assign bytes_add = bytes_sum[blrt_pkg::BYTES_W] ? blrt_pkg::BYTES_MAX :
		bytes_sum[blrt_pkg::BYTES_W-1:0];

	always_comb begin
		stat.needs_check = (op_q == blrt_pkg::OP_ENFORCE) ||
			((op_q == blrt_pkg::OP_LOAD) && !a_res);
		stat.is_load = (op_q == blrt_pkg::OP_LOAD);
		stat.chk_pass = (budget_q == '0) || (!(add > budget_q) && !need);
		stat.chk_fail = (budget_q != '0) &&
			((add > budget_q) || (need && (done_q == blrt_pkg::MAX_EVICT)));
		stat.scan_last = (scan_q == blrt_pkg::IDX_W'(E - 1));
		stat.found = found_q;
	end

	// Payload tables, latched item, scan best and result register, all without reset.
	always_ff @(posedge clk) begin
		if (cmd.install) begin
			eb_q[idx_q] <= size_q;
			lu_q[idx_q] <= next_ord;
		end else if (cmd.exec && a_res && ((op_q == blrt_pkg::OP_TOUCH) ||
				(op_q == blrt_pkg::OP_LOAD) ||
				((op_q == blrt_pkg::OP_RETAIN) && (a_ret != blrt_pkg::CNT_MAX)))) begin
			lu_q[idx_q] <= next_ord;
		end
		if (cmd.latch) begin
			op_q <= item.opcode;
			idx_q <= item.entry_index;
			size_q <= item.load_size;
		end
		if (cmd.scan_step && a_cand && (!found_q || (a_lu < best_lu_q))) begin
			best_q <= scan_q;
			best_lu_q <= a_lu;
		end
		if (cmd.fin) begin
			out_q <= '{evicted: 1'b0, result_index: idx_q, status: st_q,
				used_bytes: bytes_q, last: 1'b1};
		end else if (cmd.evict) begin
			out_q <= '{evicted: 1'b1, result_index: best_q, status: blrt_pkg::ST_OK,
				used_bytes: bytes_sub, last: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
			prot_q <= '0;
			for (int i = 0; i < E; i++) begin
				ret_q[i] <= '0;
				dep_q[i] <= '0;
			end
			bytes_q <= '0;
			acc_q <= '0;
			budget_q <= '0;
			strobe_q <= 1'b0;
			st_q <= blrt_pkg::ST_OK;
			done_q <= '0;
			scan_q <= '0;
			found_q <= 1'b0;
		end else begin
			strobe_q <= cmd.fin || cmd.evict;
			if (cfg_we) begin
				budget_q <= cfg_data;
			end
			if (cmd.latch) begin
				done_q <= '0;
			end
			if (cmd.exec) begin
				st_q <= blrt_pkg::ST_OK;
				case (op_q)
					blrt_pkg::OP_TOUCH, blrt_pkg::OP_LOAD: begin
						if (a_res) begin
							acc_q <= next_ord;
						end else if (op_q == blrt_pkg::OP_TOUCH) begin
							st_q <= blrt_pkg::ST_NOT_RES;
						end
					end
					blrt_pkg::OP_RETAIN: begin
						if (!a_res) begin
							st_q <= blrt_pkg::ST_NOT_RES;
						end else if (a_ret == blrt_pkg::CNT_MAX) begin
							st_q <= blrt_pkg::ST_LIMIT;
						end else begin
							ret_q[idx_q] <= a_ret + blrt_pkg::CNT_W'(1);
							acc_q <= next_ord;
						end
					end
					blrt_pkg::OP_RELEASE: begin
						if (!a_res) begin
							st_q <= blrt_pkg::ST_NOT_RES;
						end else if (a_ret == '0) begin
							st_q <= blrt_pkg::ST_LIMIT;
						end else begin
							ret_q[idx_q] <= a_ret - blrt_pkg::CNT_W'(1);
						end
					end
					blrt_pkg::OP_UNLOAD: begin
						if (!a_res || (a_ret != '0) || (a_dep != '0)) begin
							st_q <= blrt_pkg::ST_NOT_RES;
						end else begin
							res_q[idx_q] <= 1'b0;
							bytes_q <= bytes_sub;
						end
					end
					blrt_pkg::OP_PIN: begin
						if (a_dep == blrt_pkg::CNT_MAX) begin
							st_q <= blrt_pkg::ST_LIMIT;
						end else begin
							dep_q[idx_q] <= a_dep + blrt_pkg::CNT_W'(1);
						end
					end
					blrt_pkg::OP_UNPIN: begin
						if (a_dep == '0) begin
							st_q <= blrt_pkg::ST_LIMIT;
						end else begin
							dep_q[idx_q] <= a_dep - blrt_pkg::CNT_W'(1);
						end
					end
					blrt_pkg::OP_ENFORCE: begin
					end
					blrt_pkg::OP_PROTECT: begin
						prot_q[idx_q] <= 1'b1;
					end
					default: begin
						st_q <= blrt_pkg::ST_NOT_RES;
					end
				endcase
			end
			if (cmd.install) begin
				res_q[idx_q] <= 1'b1;
				ret_q[idx_q] <= '0;
				acc_q <= next_ord;
				bytes_q <= bytes_add;
			end
			if (cmd.fail) begin
				st_q <= blrt_pkg::ST_BUDGET;
			end
			if (cmd.clr_prot) begin
				prot_q <= '0;
			end
			if (cmd.scan_start) begin
				scan_q <= '0;
				found_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				scan_q <= scan_q + blrt_pkg::IDX_W'(1);
				if (a_cand) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.evict) begin
				res_q[best_q] <= 1'b0;
				ret_q[best_q] <= '0;
				bytes_q <= bytes_sub;
				done_q <= done_q + blrt_pkg::DONE_W'(1);
			end
		end
	end

	assign result = out_q;
	assign result_valid = strobe_q;

endmodule
